### rtl/ztt_pkg.sv
// Shared types and constants of the Zobrist-hashed transposition table.
`default_nettype none
package ztt_pkg;

  localparam int FUNC_W  = 2;
  localparam int CELL_W  = 4;
  localparam int KEY_W   = 31;
  localparam int HALF_W  = 32;
  localparam int BOARD_W = 64;
  localparam int DATA_W  = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEY_WRITE = 2'd0,
    FUNC_INSERT    = 2'd1,
    FUNC_LOOKUP    = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef struct packed {
    logic               valid;
    logic [BOARD_W-1:0] board;
    logic [DATA_W-1:0]  cost;
    logic [DATA_W-1:0]  bound;
  } entry_t;

endpackage
`default_nettype wire

### rtl/zobrist_transposition_table_core.sv
// Top level of the Zobrist-hashed, direct-mapped, always-replace transposition table.
// One item is in flight at a time. A key write, or an item with the unused code,
// goes from acceptance straight to the response state. An insert or lookup passes
// through the key bank read, the slot reduction (the low hash bits when TABLE_ENTRIES
// is a power of two, else a reciprocal multiplication in registered steps) and the
// registered read of the slot memory. A finished result waits in the output
// register, and while out_ready is low with a result held there the next result
// cannot be written. After reset a clearing pass empties every slot, and in_ready
// stays low until it is done. Keys must be written before positions that use them
// are hashed.
`default_nettype none
module zobrist_transposition_table_core
  import ztt_pkg::*;
#(
  parameter int CELLS         = 16,
  parameter int VALUE_LEVELS  = 16,
  parameter int TABLE_ENTRIES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [HALF_W-1:0]  board_lo,
  input  wire logic [HALF_W-1:0]  board_hi,
  input  wire logic [DATA_W-1:0]  entry_cost,
  input  wire logic [DATA_W-1:0]  bound,
  input  wire logic [CELL_W-1:0]  key_cell,
  input  wire logic [CELL_W-1:0]  key_value,
  input  wire logic [KEY_W-1:0]   key_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    entry_present,
  output logic [HALF_W-1:0]       stored_board_lo,
  output logic [HALF_W-1:0]       stored_board_hi,
  output logic [DATA_W-1:0]       stored_cost,
  output logic [DATA_W-1:0]       stored_bound
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_SLOT,
    ST_RESP
  } state_t;

  state_t           state;
  func_t            item_func;
  entry_t           item_entry;
  logic             in_fire;
  logic             resp_go;
  logic [KEY_W-1:0] hash;
  logic             mod_done;
  logic [IDX_W-1:0] slot;
  entry_t           rd_data;
  logic             clearing;
  logic             tbl_rd;
  logic             tbl_wr;
  logic             table_op;

  assign in_ready = (state == ST_IDLE) && !clearing;
  assign in_fire  = in_valid && in_ready;
  assign resp_go  = (state == ST_RESP) && (!out_valid || out_ready);
  assign table_op = (item_func == FUNC_INSERT) || (item_func == FUNC_LOOKUP);
  assign tbl_rd   = (state == ST_SLOT) && mod_done;
  assign tbl_wr   = resp_go && (item_func == FUNC_INSERT);

  ztt_key_hash #(
    .CELLS        (CELLS),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_key_hash (
    .clk      (clk),
    .wr_en    (in_fire && (func_t'(func) == FUNC_KEY_WRITE)),
    .wr_cell  (key_cell),
    .wr_value (key_value),
    .wr_key   (key_word),
    .rd_en    (in_fire),
    .rd_board ({board_hi, board_lo}),
    .hash     (hash)
  );

  ztt_slot_mod #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_slot_mod (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_HASH),
    .hash  (hash),
    .done  (mod_done),
    .slot  (slot)
  );

  ztt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (tbl_rd),
    .rd_addr  (slot),
    .rd_data  (rd_data),
    .wr_en    (tbl_wr),
    .wr_addr  (slot),
    .wr_data  (item_entry),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (resp_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if ((func_t'(func) == FUNC_INSERT) || (func_t'(func) == FUNC_LOOKUP)) begin
              state <= ST_HASH;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_HASH: begin
          state <= ST_SLOT;
        end
        ST_SLOT: begin
          if (mod_done) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end

    if (in_fire) begin
      item_func        <= func_t'(func);
      item_entry.valid <= 1'b1;
      item_entry.board <= {board_hi, board_lo};
      item_entry.cost  <= entry_cost;
      item_entry.bound <= bound;
    end

    if (resp_go) begin
      entry_present <= table_op && rd_data.valid;
      // Only a lookup of an occupied slot returns its contents.
      if ((item_func == FUNC_LOOKUP) && rd_data.valid) begin
        stored_board_lo <= rd_data.board[HALF_W-1:0];
        stored_board_hi <= rd_data.board[BOARD_W-1:HALF_W];
        stored_cost     <= rd_data.cost;
        stored_bound    <= rd_data.bound;
      end else begin
        stored_board_lo <= '0;
        stored_board_hi <= '0;
        stored_cost     <= '0;
        stored_bound    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ztt_key_hash.sv
// Zobrist key store, one bank per cell, and the XOR hash of a position.
`default_nettype none
module ztt_key_hash
  import ztt_pkg::*;
#(
  parameter int CELLS        = 16,
  parameter int VALUE_LEVELS = 16
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [CELL_W-1:0]  wr_cell,
  input  wire logic [CELL_W-1:0]  wr_value,
  input  wire logic [KEY_W-1:0]   wr_key,
  input  wire logic               rd_en,
  input  wire logic [BOARD_W-1:0] rd_board,
  output logic      [KEY_W-1:0]   hash
);

  localparam int VAL_AW = $clog2(VALUE_LEVELS);

  logic [KEY_W-1:0] rd_key [CELLS];
  logic             rd_hit [CELLS];
  logic             wr_ok;

  assign wr_ok = ({1'b0, wr_cell} < (CELL_W+1)'(CELLS)) &&
                 ({1'b0, wr_value} < (CELL_W+1)'(VALUE_LEVELS));

  for (genvar c = 0; c < CELLS; c++) begin : g_bank
    logic [KEY_W-1:0]  bank [VALUE_LEVELS];
    logic [CELL_W-1:0] cell_val;

    assign cell_val = rd_board[CELL_W*c +: CELL_W];

    always_ff @(posedge clk) begin
      if (wr_en && wr_ok && (wr_cell == CELL_W'(c))) begin
        bank[wr_value[VAL_AW-1:0]] <= wr_key;
      end
      if (rd_en) begin
        rd_key[c] <= bank[cell_val[VAL_AW-1:0]];
        // A cell value past the last level contributes no key.
        rd_hit[c] <= ({1'b0, cell_val} < (CELL_W+1)'(VALUE_LEVELS));
      end
    end
  end

  always_comb begin
    hash = '0;
    for (int c = 0; c < CELLS; c++) begin
      if (rd_hit[c]) begin
        hash = hash ^ rd_key[c];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ztt_slot_mod.sv
// Reduction of the hash to a slot index, modulo the table depth.
`default_nettype none
module ztt_slot_mod
  import ztt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [KEY_W-1:0]                 hash,
  output logic                                  done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      slot
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
    // A power-of-two depth keeps the low hash bits.
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        slot <= hash[IDX_W-1:0];
      end
    end
  end else begin : g_recip
    // The quotient comes from a scaled reciprocal that is exact for every hash
    // of KEY_W bits. The remainder is below the depth, so only the low index
    // bits of the hash and of quotient times depth are needed.
    localparam int SHIFT_W = KEY_W + IDX_W;
    localparam int PROD_W  = 2 * KEY_W + 1;
    localparam int QUOT_W  = PROD_W - SHIFT_W;
    localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT_W) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam logic [KEY_W:0]   RECIP   = RECIP_FULL[KEY_W:0];
    localparam logic [IDX_W-1:0] MOD_LOW = IDX_W'(TABLE_ENTRIES);

    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  hash_low;
    logic [QUOT_W-1:0] quot;
    logic [IDX_W-1:0]  qm_low;
    logic              stage1;
    logic              stage2;

    assign quot = prod[PROD_W-1:SHIFT_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage1 <= 1'b0;
        stage2 <= 1'b0;
        done   <= 1'b0;
      end else begin
        stage1 <= start;
        stage2 <= stage1;
        done   <= stage2;
      end
      if (start) begin
        prod     <= PROD_W'(hash) * PROD_W'(RECIP);
        hash_low <= hash[IDX_W-1:0];
      end
      if (stage1) begin
        qm_low <= quot[IDX_W-1:0] * MOD_LOW;
      end
      if (stage2) begin
        slot <= hash_low - qm_low;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ztt_table.sv
// Slot memory with a registered read and a clearing pass after reset.
`default_nettype none
module ztt_table
  import ztt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
  output entry_t                                rd_data,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
  input  wire entry_t                           wr_data,
  output logic                                  clearing
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  entry_t           mem [TABLE_ENTRIES];
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
